>>> design/matrix_vector_transform_4x4_defines.svh
// Assertion macros for the 4x4 matrix-vector transform.
// Used by the top level; no other dependencies.
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, suspended while reset is high
`define MVT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs during reset
`define MVT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MVT_ASSERT(lbl, prop, msg)
`define MVT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> design/mvt_pkg.sv
// Shared types, constants and reset values for the 4x4 matrix-vector transform.
// No dependencies; every other file but the defines header imports this package.
package mvt_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_COLS   = 4;
  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 64;
  localparam int HALF_W     = 32;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);

  // Product, pair sum and full dot-product widths
  localparam int PROD_W = COEF_WIDTH + DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int TOT_W  = PROD_W + 2;

  typedef logic signed [DATA_W-1:0]     data_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [PAIR_W-1:0]     pair_t;
  typedef logic signed [TOT_W-1:0]      tot_t;
  typedef logic [REG_W-1:0]             cfg_reg_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

  typedef data_t vec_t      [NUM_COLS];
  typedef coef_t coef_mat_t [NUM_ROWS][NUM_COLS];
  typedef prod_t prod_mat_t [NUM_ROWS][NUM_COLS];
  typedef pair_t pair_mat_t [NUM_ROWS][2];
  typedef tot_t  tot_vec_t  [NUM_ROWS];

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
    data_t w;
    logic  overflow;
  } res_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5,
    REG_ROW3_COLS01 = 3'd6,
    REG_ROW3_COLS23 = 3'd7
  } cfg_reg_e;

  localparam cfg_reg_t COEF_ONE = cfg_reg_t'(1) << FRAC_BITS;

  // Identity matrix: 1.0 in each diagonal slot
  function automatic cfg_reg_t cfg_reset_value(cfg_idx_t idx);
    cfg_reg_t value;
    unique case (cfg_reg_e'(idx))
      REG_ROW0_COLS01: value = COEF_ONE;
      REG_ROW1_COLS01: value = COEF_ONE << HALF_W;
      REG_ROW2_COLS23: value = COEF_ONE;
      REG_ROW3_COLS23: value = COEF_ONE << HALF_W;
      default:         value = '0;
    endcase
    return value;
  endfunction

endpackage

>>> design/mvt_stream_if.sv
// Valid/ready channel interfaces for input vectors and result vectors.
// Depends on mvt_pkg for the payload types.
interface mvt_vec_if import mvt_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t in_x;
  data_t in_y;
  data_t in_z;
  data_t in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

interface mvt_res_if import mvt_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t out_x;
  data_t out_y;
  data_t out_z;
  data_t out_w;
  logic  overflow;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output overflow, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  input overflow, output ready);
endinterface

>>> design/mvt_cfg_regs.sv
// Coefficient register file: eight 64-bit registers, two coefficients each.
// Depends on mvt_pkg.
module mvt_cfg_regs import mvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  cfg_reg_t  cfg_data,
  output coef_mat_t coef
);

  cfg_reg_t regs [NUM_REGS];

  // Load identity on reset, take writes afterwards
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= cfg_reset_value(cfg_idx_t'(i));
      end
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // Unpack: even column in the low half, odd column in the high half
  always_comb begin
    cfg_reg_t          word;
    logic [HALF_W-1:0] half;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        word = regs[CFG_IDX_W'(2 * r + (c >> 1))];
        half = c[0] ? word[REG_W-1:HALF_W] : word[HALF_W-1:0];
        coef[r][c] = half[COEF_WIDTH-1:0];
      end
    end
  end

endmodule

>>> design/mvt_mul_stage.sv
// First pipeline stage: sixteen signed coefficient-by-component products.
// Depends on mvt_pkg.
module mvt_mul_stage import mvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  vec_t      vec,
  input  coef_mat_t coef,
  output logic      valid,
  input  logic      out_ready,
  output prod_mat_t prod
);

  // Take an item when empty or when the next stage drains this one
  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Register each product
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          prod[r][c] <= prod_t'(coef[r][c]) * prod_t'(vec[c]);
        end
      end
    end
  end

endmodule

>>> design/mvt_sum_stage.sv
// Second and third pipeline stages: pairwise sums, then the full row sums.
// Depends on mvt_pkg.
module mvt_sum_stage import mvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  prod_mat_t prod,
  output logic      valid,
  input  logic      out_ready,
  output tot_vec_t  tot
);

  logic      pair_valid;
  logic      tot_ready;
  pair_mat_t pair;

  // Ready chain across the two levels
  assign tot_ready = !valid || out_ready;
  assign in_ready  = !pair_valid || tot_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      valid      <= 1'b0;
    end else begin
      if (in_ready) begin
        pair_valid <= in_valid;
      end
      if (tot_ready) begin
        valid <= pair_valid;
      end
    end
  end

  // Add columns 0+1 and 2+3 of each row
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int k = 0; k < 2; k++) begin
          pair[r][k] <= pair_t'(prod[r][2 * k]) + pair_t'(prod[r][2 * k + 1]);
        end
      end
    end
  end

  // Combine the two halves of each row
  always_ff @(posedge clk) begin
    if (pair_valid && tot_ready) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        tot[r] <= tot_t'(pair[r][0]) + tot_t'(pair[r][1]);
      end
    end
  end

endmodule

>>> design/mvt_sat_stage.sv
// Last pipeline stage: scale down, saturate to 32 bits, flag overflow.
// Holds the output register. Depends on mvt_pkg.
module mvt_sat_stage import mvt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  tot_vec_t tot,
  output logic     valid,
  input  logic     out_ready,
  output res_t     res
);

  data_t sat_val [NUM_ROWS];
  logic  sat_ovf;

  // Floor shift, then clamp where the upper bits are not a sign extension
  always_comb begin
    tot_t                sh;
    logic [TOT_W-DATA_W:0] hi;
    sat_ovf = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      sh = tot[r] >>> FRAC_BITS;
      hi = sh[TOT_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
        sat_val[r] = sh[DATA_W-1:0];
      end else begin
        sat_val[r] = sh[TOT_W-1] ? DATA_MIN : DATA_MAX;
        sat_ovf    = 1'b1;
      end
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res.x        <= sat_val[0];
      res.y        <= sat_val[1];
      res.z        <= sat_val[2];
      res.w        <= sat_val[3];
      res.overflow <= sat_ovf;
    end
  end

endmodule

>>> design/matrix_vector_transform_4x4.sv
// Top level of the 4x4 fixed-point matrix-vector transform.
// Depends on mvt_pkg, mvt_stream_if, the stage modules and the defines header.
//
//   channel   direction  payload                              handshake
//   vec_in    in         in_x in_y in_z in_w (Q16.16)         valid/ready
//   res_out   out        out_x out_y out_z out_w overflow     valid/ready
//   cfg       in         cfg_index, cfg_data (64 bits)        cfg_we, no wait
//
// One item per cycle sustained while the output is ready; four register
// stages (multiplier array, pair adders, row adders, saturate/output register).
// Reset clears all valid bits and loads the identity matrix.
// A stalled output holds its item; each stage holds while the next is full,
// and empty stages keep accepting, so bubbles close up under back-pressure.
`include "matrix_vector_transform_4x4_defines.svh"

module matrix_vector_transform_4x4 import mvt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  cfg_reg_t         cfg_data,
  mvt_vec_if.sink          vec_in,
  mvt_res_if.source        res_out
);

  coef_mat_t coef;
  vec_t      vec;
  prod_mat_t prod;
  tot_vec_t  tot;
  res_t      res;
  logic      mul_valid;
  logic      sum_ready;
  logic      sum_valid;
  logic      sat_ready;

  assign vec[0] = vec_in.in_x;
  assign vec[1] = vec_in.in_y;
  assign vec[2] = vec_in.in_z;
  assign vec[3] = vec_in.in_w;

  mvt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  mvt_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec_in.valid),
    .in_ready  (vec_in.ready),
    .vec       (vec),
    .coef      (coef),
    .valid     (mul_valid),
    .out_ready (sum_ready),
    .prod      (prod)
  );

  mvt_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (sum_ready),
    .prod      (prod),
    .valid     (sum_valid),
    .out_ready (sat_ready),
    .tot       (tot)
  );

  mvt_sat_stage u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sat_ready),
    .tot       (tot),
    .valid     (res_out.valid),
    .out_ready (res_out.ready),
    .res       (res)
  );

  // Drive the result channel from the output register
  assign res_out.out_x    = res.x;
  assign res_out.out_y    = res.y;
  assign res_out.out_z    = res.z;
  assign res_out.out_w    = res.w;
  assign res_out.overflow = res.overflow;

  // An accepted item reaches the output when the output stays ready
  property p_latency;
    vec_in.valid && vec_in.ready ##1 res_out.ready [*3] |=> res_out.valid;
  endproperty

  // Overflow only with a clamped component
  property p_ovf_clamped;
    res_out.valid && res_out.overflow |->
      res_out.out_x == DATA_MAX || res_out.out_x == DATA_MIN ||
      res_out.out_y == DATA_MAX || res_out.out_y == DATA_MIN ||
      res_out.out_z == DATA_MAX || res_out.out_z == DATA_MIN ||
      res_out.out_w == DATA_MAX || res_out.out_w == DATA_MIN;
  endproperty

  // A ready sink lets the whole pipeline advance
  `MVT_ASSERT(a_ready_flow, res_out.ready |-> vec_in.ready, "input stalled while output ready")
  // Reset empties the pipeline
  `MVT_ASSERT_RST(a_rst_empty, rst |=> !res_out.valid, "result valid right after reset")
  // An accepted item reaches the output when the output stays ready
  `MVT_ASSERT(a_latency, p_latency, "item lost in pipeline")
  // Overflow only with a clamped component
  `MVT_ASSERT(a_ovf_clamped, p_ovf_clamped, "overflow without clamped value")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 4x4 fixed-point matrix-vector transform.
// Depends on mvt_pkg, the mvt_vec_if/mvt_res_if channels and the RTL top level.
module testbench;
  import mvt_pkg::*;

  localparam int    CYCLE_LIMIT  = 100000;
  localparam int    DRAIN_CYCLES = 8;
  localparam data_t ONE_Q16      = 32'sh0001_0000;
  localparam data_t HALF_Q16     = 32'sh0000_8000;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  cfg_reg_t cfg_data;

  mvt_vec_if vec_in ();
  mvt_res_if res_out ();

  matrix_vector_transform_4x4 dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vec_in    (vec_in),
    .res_out   (res_out)
  );

  // Shadow copy of the coefficient registers and the results still owed
  cfg_reg_t coef_shadow [NUM_REGS];
  res_t     pending_results [$];
  int       error_count = 0;
  int       cycle_count = 0;
  bit       sender_gaps = 1'b1;
  bit       sink_stalls = 1'b1;
  int       hold_cycles = 0;

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Matrix times vector: exact sum of products, floor shift, saturate per row
  function automatic res_t transform_vector(data_t vx, data_t vy, data_t vz, data_t vw);
    data_t             comp [NUM_COLS];
    data_t             row_out [NUM_ROWS];
    cfg_reg_t          regv;
    coef_t             k;
    logic signed [67:0] acc;
    res_t              r;
    comp = '{vx, vy, vz, vw};
    r.overflow = 1'b0;
    for (int row = 0; row < NUM_ROWS; row++) begin
      acc = '0;
      for (int col = 0; col < NUM_COLS; col++) begin
        regv = coef_shadow[row * 2 + col / 2];
        k = (col % 2 == 1) ? coef_t'(regv[HALF_W +: COEF_WIDTH]) : coef_t'(regv[0 +: COEF_WIDTH]);
        acc += k * comp[col];
      end
      acc = acc >>> FRAC_BITS;
      if (acc > DATA_MAX) begin
        row_out[row] = DATA_MAX;
        r.overflow = 1'b1;
      end else if (acc < DATA_MIN) begin
        row_out[row] = DATA_MIN;
        r.overflow = 1'b1;
      end else begin
        row_out[row] = data_t'(acc);
      end
    end
    r.x = row_out[0];
    r.y = row_out[1];
    r.z = row_out[2];
    r.w = row_out[3];
    return r;
  endfunction

  function automatic data_t extreme_value();
    case ($urandom_range(0, 4))
      0:       return DATA_MAX;
      1:       return DATA_MIN;
      2:       return '0;
      3:       return -1;
      default: return ONE_Q16;
    endcase
  endfunction

  // Mostly moderate magnitudes, some full-range and boundary values
  function automatic data_t random_component();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return data_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      5, 6, 7:       return data_t'($urandom);
      8:             return extreme_value();
      default:       return data_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic coef_mat_t random_matrix();
    coef_mat_t m;
    for (int row = 0; row < NUM_ROWS; row++) begin
      for (int col = 0; col < NUM_COLS; col++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: m[row][col] = coef_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
          4, 5:       m[row][col] = coef_t'($urandom);
          6:          m[row][col] = '0;
          7:          m[row][col] = ONE_Q16;
          8:          m[row][col] = -ONE_Q16;
          default:    m[row][col] = extreme_value();
        endcase
      end
    end
    return m;
  endfunction

  function automatic coef_mat_t fill_matrix(coef_t v);
    coef_mat_t m;
    foreach (m[row, col]) m[row][col] = v;
    return m;
  endfunction

  function automatic coef_mat_t diag_matrix(coef_t d);
    coef_mat_t m;
    foreach (m[row, col]) m[row][col] = (row == col) ? d : '0;
    return m;
  endfunction

  // Drive one register write; the caller drops the write enable
  task automatic write_coef_reg(cfg_reg_e idx, cfg_reg_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    coef_shadow[idx] = value;
  endtask

  task automatic load_matrix(coef_mat_t m);
    write_coef_reg(REG_ROW0_COLS01, {m[0][1], m[0][0]});
    write_coef_reg(REG_ROW0_COLS23, {m[0][3], m[0][2]});
    write_coef_reg(REG_ROW1_COLS01, {m[1][1], m[1][0]});
    write_coef_reg(REG_ROW1_COLS23, {m[1][3], m[1][2]});
    write_coef_reg(REG_ROW2_COLS01, {m[2][1], m[2][0]});
    write_coef_reg(REG_ROW2_COLS23, {m[2][3], m[2][2]});
    write_coef_reg(REG_ROW3_COLS01, {m[3][1], m[3][0]});
    write_coef_reg(REG_ROW3_COLS23, {m[3][3], m[3][2]});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one vector item, hold it until accepted, then record its result
  task automatic send_vector(data_t vx, data_t vy, data_t vz, data_t vw);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      vec_in.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    vec_in.valid <= 1'b1;
    vec_in.in_x  <= vx;
    vec_in.in_y  <= vy;
    vec_in.in_z  <= vz;
    vec_in.in_w  <= vw;
    do @(posedge clk); while (!vec_in.ready);
    pending_results.push_back(transform_vector(vx, vy, vz, vw));
  endtask

  task automatic send_random_vectors(int count);
    repeat (count) send_vector(random_component(), random_component(),
                               random_component(), random_component());
  endtask

  // Stop offering and let every owed result come out
  task automatic wait_drain();
    vec_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each accepted result item with the oldest owed result
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_out.valid && res_out.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with no vector outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_x", want.x, res_out.out_x);
        check_field("out_y", want.y, res_out.out_y);
        check_field("out_z", want.z, res_out.out_z);
        check_field("out_w", want.w, res_out.out_w);
        check_field("overflow", want.overflow, res_out.overflow);
      end
    end
  end

  // Result ready: random stall bursts, plus a long hold-off on request
  initial begin : sink_ready
    res_out.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        res_out.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        res_out.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        res_out.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Identity after reset passes every vector through unchanged
  task automatic test_identity_after_reset();
    send_vector('0, '0, '0, '0);
    send_vector(DATA_MAX, DATA_MIN, -1, ONE_Q16);
    send_vector(DATA_MIN, DATA_MAX, ONE_Q16, -1);
    send_vector(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0);
    send_vector(32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0, 32'sh0F0F_0F0F);
  endtask

  // Positive and negative saturation with the largest coefficients
  task automatic test_saturation();
    wait_drain();
    load_matrix(fill_matrix(DATA_MAX));
    send_vector(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
    send_vector(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
    send_vector(1, '0, '0, '0);
    send_vector(-1, '0, '0, '0);
    wait_drain();
    load_matrix(fill_matrix(DATA_MIN));
    send_vector(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
    send_vector(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
  endtask

  // Negative fractions round toward minus infinity; fractions carry across products
  task automatic test_floor_rounding();
    wait_drain();
    load_matrix(diag_matrix(HALF_Q16));
    send_vector(-1, -1, -1, -1);
    send_vector(1, 1, 1, 1);
    wait_drain();
    load_matrix(fill_matrix(HALF_Q16));
    send_vector(1, 1, 1, 1);
    wait_drain();
    load_matrix(diag_matrix(-HALF_Q16));
    send_vector(1, 1, 1, 1);
  endtask

  // Registers all ones and all zeros
  task automatic test_register_extremes();
    wait_drain();
    load_matrix(fill_matrix(-1));
    send_vector(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
    send_vector(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
    wait_drain();
    load_matrix(fill_matrix('0));
    send_vector(DATA_MAX, DATA_MIN, -1, ONE_Q16);
    send_vector(DATA_MIN, DATA_MAX, 32'sh5555_5555, 32'shAAAA_AAAA);
  endtask

  // Hold off the result side long enough to fill the pipeline and stall the input
  task automatic test_output_backpressure();
    wait_drain();
    load_matrix(random_matrix());
    sender_gaps = 1'b0;
    hold_cycles = 60;
    send_random_vectors(40);
    sender_gaps = 1'b1;
    wait_drain();
  endtask

  // Random matrices, random vectors; the last phases run with no idling
  task automatic test_random_transforms();
    for (int phase = 0; phase < 12; phase++) begin
      wait_drain();
      if (phase >= 10) begin
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      load_matrix(random_matrix());
      send_random_vectors(105);
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_ROW0_COLS01;
    cfg_data     <= '0;
    vec_in.valid <= 1'b0;
    vec_in.in_x  <= '0;
    vec_in.in_y  <= '0;
    vec_in.in_z  <= '0;
    vec_in.in_w  <= '0;
    // Reset contents: identity matrix
    foreach (coef_shadow[i]) coef_shadow[i] = '0;
    coef_shadow[REG_ROW0_COLS01] = cfg_reg_t'(ONE_Q16);
    coef_shadow[REG_ROW1_COLS01] = cfg_reg_t'(ONE_Q16) << HALF_W;
    coef_shadow[REG_ROW2_COLS23] = cfg_reg_t'(ONE_Q16);
    coef_shadow[REG_ROW3_COLS23] = cfg_reg_t'(ONE_Q16) << HALF_W;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_after_reset();
    test_saturation();
    test_floor_rounding();
    test_register_extremes();
    test_output_backpressure();
    test_random_transforms();
    wait_drain();

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
